FILE: rtl/core/rts_pkg.sv
// ----------------------------------------------------------------------------
// rts_pkg
// types, op codes and constants shared by the task scheduler files
// ----------------------------------------------------------------------------
`default_nettype none
package rts_pkg;
	localparam int TASKS_DEF = 16;
	localparam int SEMAPHORES_DEF = 8;
	localparam int EVENT_GROUPS_DEF = 8;
	localparam int PRIORITY_BITS_DEF = 8;

	typedef enum logic [3:0] {
		OP_CREATE = 4'd0, OP_RUN = 4'd1, OP_DELAY = 4'd2, OP_TICK = 4'd3,
		OP_ISR_ENTER = 4'd4, OP_ISR_EXIT = 4'd5, OP_SEM_CREATE = 4'd6,
		OP_SEM_PEND = 4'd7, OP_SEM_POST = 4'd8, OP_EV_CREATE = 4'd9,
		OP_EV_PEND = 4'd10, OP_EV_SET = 4'd11, OP_EV_RESET = 4'd12
	} op_t;

	typedef enum logic [2:0] {
		TS_FREE = 3'd0, TS_READY = 3'd1, TS_DELAYED = 3'd2, TS_SEM = 3'd3,
		TS_EVENT = 3'd4
	} tstat_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0, ST_BLOCKED = 2'd1, ST_FULL = 2'd2, ST_INVALID = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE, S_OP, S_SCAN, S_WAIT, S_POST, S_SCHED, S_OUT
	} fsm_t;
endpackage
`default_nettype wire

FILE: rtl/core/rts_if.sv
// ----------------------------------------------------------------------------
// rts_in_if / rts_out_if
// valid/ready channels carrying scheduler ops and results
// ----------------------------------------------------------------------------
`default_nettype none
interface rts_in_if;
	logic valid;
	logic ready;
	logic [3:0] op;
	logic [7:0] priority_req;
	logic [15:0] delay_ticks;
	logic [2:0] obj_index;
	logic [15:0] init_value;
	logic [15:0] mask;
	logic wait_all;
	modport source (output valid, op, priority_req, delay_ticks, obj_index,
		init_value, mask, wait_all, input ready);
	modport sink (input valid, op, priority_req, delay_ticks, obj_index,
		init_value, mask, wait_all, output ready);
endinterface

interface rts_out_if;
	logic valid;
	logic ready;
	logic [3:0] current_task;
	logic switched;
	logic [1:0] status;
	logic [15:0] flags_value;
	logic [3:0] new_task_index;
	modport source (output valid, current_task, switched, status, flags_value,
		new_task_index, input ready);
	modport sink (input valid, current_task, switched, status, flags_value,
		new_task_index, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rtos_task_scheduler.sv
// ----------------------------------------------------------------------------
// rtos_task_scheduler
// priority task scheduler with semaphores and event groups
// ----------------------------------------------------------------------------
// each op runs S_OP, a pass over the table in S_SCAN (wakeup updates for
// tick, post and set), S_WAIT and S_POST, then a ready-task pick pass in
// S_SCHED when it schedules, and S_OUT; each table pass reads one
// entry per cycle through the task memory read port
// one op at a time; the next op is taken in the idle cycle after the result
// register is loaded; a result still waiting holds the op in S_OUT and so
// holds off the next op
// reset clears control state, task states (valid per entry) and counters
`default_nettype none
module rtos_task_scheduler
	import rts_pkg::*;
#(
	parameter int TASKS = TASKS_DEF,
	parameter int SEMAPHORES = SEMAPHORES_DEF,
	parameter int EVENT_GROUPS = EVENT_GROUPS_DEF,
	parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	rts_in_if.sink in_ch,
	rts_out_if.source out_ch
);
	localparam int TW = $clog2(TASKS);
	localparam int SW = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
	localparam int EW = (EVENT_GROUPS > 1) ? $clog2(EVENT_GROUPS) : 1;
	localparam logic [PRIORITY_BITS-1:0] PMAX = '1;

	// task record kept in one memory (reset free); status lives in flip-flops
	typedef struct packed {
		logic [PRIORITY_BITS-1:0] prio;
		logic [15:0] dly;
		logic [2:0] wobj;
		logic [15:0] wmask;
		logic wall;
	} trec_t;

	trec_t tmem [TASKS];
	trec_t rd_s1;
	tstat_t tstat_q [TASKS];
	logic [15:0] sem_q [SEMAPHORES];
	logic [15:0] evf_q [EVENT_GROUPS];

	logic [TW:0] created_q;
	logic [TW-1:0] run_q;
	logic has_run_q, started_q;
	logic [7:0] isr_q;
	logic [31:0] swcnt_q;

	// latched op
	logic [3:0] op_q;
	logic [7:0] prio_q;
	logic [15:0] dly_q, init_q, mask_q;
	logic [2:0] obj_q;
	logic wall_q;

	fsm_t st_q, st_d;
	logic [TW:0] idx_q;        // scan counter, top bit marks end
	logic [TW-1:0] ridx_s1;    // index of record in rd_s1
	logic rvalid_s1;
	logic scan_upd_q;          // wakeup pass needed (tick, post, set)
	logic sched_q;
	logic [1:0] status_q;
	logic [15:0] flags_q;
	logic [TW-1:0] newidx_q;
	logic best_v_q;
	logic [TW-1:0] best_q;
	logic [PRIORITY_BITS-1:0] bestp_q;

	// result register
	logic ovalid_q;
	logic [3:0] o_cur_q, o_new_q;
	logic o_sw_q;
	logic [1:0] o_st_q;
	logic [15:0] o_flags_q;

	// result register free to take a new result this cycle
	logic out_free;
	assign out_free = !ovalid_q || out_ch.ready;

	assign in_ch.ready = (st_q == S_IDLE);
	assign out_ch.valid = ovalid_q;
	assign out_ch.current_task = o_cur_q;
	assign out_ch.switched = o_sw_q;
	assign out_ch.status = o_st_q;
	assign out_ch.flags_value = o_flags_q;
	assign out_ch.new_task_index = o_new_q;

	logic sem_ok, ev_ok;
	assign sem_ok = {29'd0, obj_q} < 32'(SEMAPHORES);
	assign ev_ok = {29'd0, obj_q} < 32'(EVENT_GROUPS);
	logic [SW-1:0] sidx;
	logic [EW-1:0] eidx;
	assign sidx = SW'(obj_q);
	assign eidx = EW'(obj_q);
	logic [15:0] cur_flags;
	assign cur_flags = evf_q[eidx];
	logic tbl_full;
	assign tbl_full = (created_q == (TW+1)'(TASKS));

	function automatic logic met(input logic [15:0] f, input logic [15:0] m,
		input logic a);
		met = a ? ((f & m) == m) : ((f & m) != 16'd0);
	endfunction

	// memory write port (single)
	logic we;
	logic [TW-1:0] wa;
	trec_t wd;
	// running-task record write
	logic we2;
	trec_t runrec_q;
	trec_t wd3;
	// memory read address: running task during S_OP, scan index otherwise
	logic [TW-1:0] ra;
	assign ra = (st_q == S_OP) ? run_q : idx_q[TW-1:0];

	always_ff @(posedge clk) begin
		if (we) tmem[wa] <= wd;
		rd_s1 <= tmem[ra];
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= ra;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= S_IDLE;
		else st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: if (in_ch.valid && in_ch.ready) st_d = S_OP;
			S_OP: st_d = S_SCAN;
			S_SCAN: if (idx_q[TW] && !rvalid_s1) st_d = S_WAIT;
			S_WAIT: st_d = S_POST;
			S_POST: st_d = sched_q ? S_SCHED : S_OUT;
			S_SCHED: if (idx_q[TW] && !rvalid_s1) st_d = S_OUT;
			S_OUT: if (out_free) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_comb begin
		we = 1'b0;
		wa = run_q;
		wd = '0;
		if (st_q == S_OP) begin
			case (op_q)
				OP_CREATE: begin
					wa = created_q[TW-1:0];
					wd.prio = ({8'd0, prio_q} > {8'd0, 8'(PMAX)}) ? PMAX
						: PRIORITY_BITS'(prio_q);
				end
				OP_DELAY: begin
					wd = '0;
				end
				default: ;
			endcase
		end
		if (st_q == S_OP && op_q == OP_CREATE && !tbl_full) we = 1'b1;
		if (st_q == S_SCAN && rvalid_s1 && op_q == OP_TICK
			&& tstat_q[ridx_s1] == TS_DELAYED) begin
			we = 1'b1;
			wa = ridx_s1;
			wd = rd_s1;
			wd.dly = rd_s1.dly - 16'd1;
		end
		if (we2) begin
			we = 1'b1;
			wa = run_q;
			wd = wd3;
		end
	end

	// wait-field updates of the running task go into a side write on S_OP
	// through a second, narrow memory path would break one port; instead they
	// are done in S_WAIT when the scan port is idle

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASKS; i++) tstat_q[i] <= TS_FREE;
			for (int i = 0; i < SEMAPHORES; i++) sem_q[i] <= '0;
			for (int i = 0; i < EVENT_GROUPS; i++) evf_q[i] <= '0;
			created_q <= '0;
			run_q <= '0;
			has_run_q <= 1'b0;
			started_q <= 1'b0;
			isr_q <= '0;
			swcnt_q <= '0;
			idx_q <= '0;
			rvalid_s1 <= 1'b0;
			scan_upd_q <= 1'b0;
			sched_q <= 1'b0;
			status_q <= ST_DONE;
			ovalid_q <= 1'b0;
			best_v_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ch.ready) ovalid_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					idx_q <= '0;
					rvalid_s1 <= 1'b0;
				end
				S_OP: begin
					status_q <= ST_DONE;
					sched_q <= 1'b0;
					scan_upd_q <= 1'b0;
					idx_q <= '0;
					rvalid_s1 <= 1'b0;
					case (op_q)
						OP_CREATE: begin
							if (tbl_full) status_q <= ST_FULL;
							else begin
								tstat_q[created_q[TW-1:0]] <= TS_READY;
								created_q <= created_q + 1'b1;
								sched_q <= started_q;
							end
						end
						OP_RUN: begin
							started_q <= 1'b1;
							sched_q <= 1'b1;
						end
						OP_DELAY: begin
							if (dly_q != 16'd0) begin
								if (!has_run_q) status_q <= ST_INVALID;
								else begin
									tstat_q[run_q] <= TS_DELAYED;
									sched_q <= 1'b1;
								end
							end
						end
						OP_TICK: scan_upd_q <= 1'b1;
						OP_ISR_ENTER: if (isr_q != 8'hFF) isr_q <= isr_q + 8'd1;
						OP_ISR_EXIT: begin
							if (isr_q == 8'd0) status_q <= ST_INVALID;
							else begin
								isr_q <= isr_q - 8'd1;
								sched_q <= (isr_q == 8'd1) && started_q;
							end
						end
						OP_SEM_CREATE: begin
							if (!sem_ok) status_q <= ST_INVALID;
							else sem_q[sidx] <= init_q;
						end
						OP_SEM_PEND: begin
							if (!sem_ok) status_q <= ST_INVALID;
							else if (sem_q[sidx] != 16'd0) sem_q[sidx] <= sem_q[sidx] - 16'd1;
							else if (!has_run_q) status_q <= ST_INVALID;
							else begin
								tstat_q[run_q] <= TS_SEM;
								status_q <= ST_BLOCKED;
								sched_q <= 1'b1;
							end
						end
						OP_SEM_POST: begin
							if (!sem_ok) status_q <= ST_INVALID;
							else begin
								scan_upd_q <= 1'b1;
								sched_q <= (isr_q == 8'd0) && started_q;
							end
						end
						OP_EV_CREATE: begin
							if (!ev_ok) status_q <= ST_INVALID;
							else evf_q[eidx] <= init_q;
						end
						OP_EV_PEND: begin
							if (!ev_ok) status_q <= ST_INVALID;
							else if (!met(cur_flags, mask_q, wall_q)) begin
								if (!has_run_q) status_q <= ST_INVALID;
								else begin
									tstat_q[run_q] <= TS_EVENT;
									status_q <= ST_BLOCKED;
									sched_q <= 1'b1;
								end
							end
						end
						OP_EV_SET: begin
							if (!ev_ok) status_q <= ST_INVALID;
							else begin
								evf_q[eidx] <= cur_flags | mask_q;
								scan_upd_q <= 1'b1;
								sched_q <= (isr_q == 8'd0) && started_q;
							end
						end
						OP_EV_RESET: begin
							if (!ev_ok) status_q <= ST_INVALID;
							else evf_q[eidx] <= cur_flags & ~mask_q;
						end
						default: status_q <= ST_INVALID;
					endcase
					best_v_q <= 1'b0;
				end
				S_SCAN: begin
					// wakeup pass; the first cycle returns the running task's record
					if (!idx_q[TW]) idx_q <= idx_q + 1'b1;
					rvalid_s1 <= scan_upd_q && !idx_q[TW];
					if (rvalid_s1) begin
						case (op_q)
							OP_TICK: begin
								if (tstat_q[ridx_s1] == TS_DELAYED && rd_s1.dly == 16'd1)
									tstat_q[ridx_s1] <= TS_READY;
							end
							OP_SEM_POST: begin
								if (tstat_q[ridx_s1] == TS_SEM && rd_s1.wobj == obj_q
									&& (!best_v_q || rd_s1.prio < bestp_q)) begin
									best_v_q <= 1'b1;
									best_q <= ridx_s1;
									bestp_q <= rd_s1.prio;
								end
							end
							OP_EV_SET: begin
								if (tstat_q[ridx_s1] == TS_EVENT && rd_s1.wobj == obj_q
									&& met(cur_flags, rd_s1.wmask, rd_s1.wall))
									tstat_q[ridx_s1] <= TS_READY;
							end
							default: ;
						endcase
					end
				end
				S_WAIT: ;
				S_POST: begin
					if (op_q == OP_SEM_POST && status_q == ST_DONE) begin
						if (best_v_q) tstat_q[best_q] <= TS_READY;
						else if (sem_q[sidx] != 16'hFFFF) sem_q[sidx] <= sem_q[sidx] + 16'd1;
					end
					best_v_q <= 1'b0;
					idx_q <= '0;
					rvalid_s1 <= 1'b0;
				end
				S_SCHED: begin
					if (!idx_q[TW]) idx_q <= idx_q + 1'b1;
					rvalid_s1 <= !idx_q[TW];
					if (rvalid_s1 && tstat_q[ridx_s1] == TS_READY
						&& (!best_v_q || rd_s1.prio < bestp_q)) begin
						best_v_q <= 1'b1;
						best_q <= ridx_s1;
						bestp_q <= rd_s1.prio;
					end
				end
				S_OUT: begin
					// schedule decision, taken once the result register is free
					if (out_free) begin
						if (sched_q) begin
							if (!best_v_q) begin
								has_run_q <= 1'b0;
								if (status_q == ST_DONE) status_q <= ST_INVALID;
							end else begin
								if (!has_run_q || run_q != best_q) begin
									run_q <= best_q;
									swcnt_q <= swcnt_q + 32'd1;
								end
								has_run_q <= 1'b1;
							end
						end
						ovalid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// S_OUT drives the result register from the decision taken this cycle
	logic sw_now;
	logic [TW-1:0] run_now;
	logic [1:0] st_now;
	always_comb begin
		sw_now = 1'b0;
		run_now = run_q;
		st_now = status_q;
		if (sched_q) begin
			if (!best_v_q) begin
				if (status_q == ST_DONE) st_now = ST_INVALID;
			end else if (!has_run_q || run_q != best_q) begin
				sw_now = 1'b1;
				run_now = best_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			op_q <= in_ch.op;
			prio_q <= in_ch.priority_req;
			dly_q <= in_ch.delay_ticks;
			obj_q <= in_ch.obj_index;
			init_q <= in_ch.init_value;
			mask_q <= in_ch.mask;
			wall_q <= in_ch.wait_all;
		end
		if (st_q == S_OP) begin
			newidx_q <= created_q[TW-1:0];
			flags_q <= '0;
		end
		if (st_q == S_POST && op_q >= OP_EV_CREATE && op_q <= OP_EV_RESET && ev_ok)
			flags_q <= cur_flags;
		if (st_q == S_OUT && out_free) begin
			o_cur_q <= 4'(run_now);
			o_sw_q <= sw_now;
			o_st_q <= st_now;
			o_flags_q <= flags_q;
			o_new_q <= (op_q == OP_CREATE && status_q != ST_FULL) ? 4'(newidx_q) : 4'd0;
		end
	end

	// running-task record update; S_WAIT is free of scan reads and writes
	always_comb begin
		we2 = 1'b0;
		if (st_q == S_WAIT) begin
			if (op_q == OP_DELAY && dly_q != 16'd0 && status_q == ST_DONE) we2 = 1'b1;
			if ((op_q == OP_SEM_PEND || op_q == OP_EV_PEND) && status_q == ST_BLOCKED)
				we2 = 1'b1;
		end
	end

	// read-modify-write of the running task's fields: priority kept from the
	// stored copy, read back in S_SCAN's first cycle
	always_ff @(posedge clk) begin
		if (st_q == S_SCAN && idx_q == '0) runrec_q <= rd_s1;
	end

	always_comb begin
		wd3 = runrec_q;
		if (op_q == OP_DELAY) wd3.dly = dly_q;
		else begin
			wd3.wobj = obj_q;
			if (op_q == OP_EV_PEND) begin
				wd3.wmask = mask_q;
				wd3.wall = wall_q;
			end
		end
	end
endmodule
`default_nettype wire

FILE: bench/rtos_task_scheduler_tb.sv
// ----------------------------------------------------------------------------
// rtos_task_scheduler_tb
// drives kernel ops into the scheduler, predicts each result with a local
// model of the task table, semaphores and event groups, and compares fields
// ----------------------------------------------------------------------------
module rtos_task_scheduler_tb;
	import rts_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NT = 16;
	localparam int NSEM = 8;
	localparam int NEV = 8;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [3:0] op;
		logic [7:0] prio;
		logic [15:0] dly;
		logic [2:0] obj;
		logic [15:0] init;
		logic [15:0] mask;
		logic all;
	} kop_t;

	typedef struct packed {
		logic [3:0] cur;
		logic sw;
		logic [1:0] status;
		logic [15:0] flags;
		logic [3:0] newidx;
	} kres_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	rts_in_if in_ch();
	rts_out_if out_ch();

	rtos_task_scheduler u_top (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	always #5 clk = ~clk;

	// kernel state mirror
	tstat_t k_stat[NT];
	logic [7:0] k_prio[NT];
	logic [15:0] k_dly[NT];
	logic [2:0] k_wobj[NT];
	logic [15:0] k_wmask[NT];
	logic k_wall[NT];
	int k_created;
	logic [3:0] k_run;
	bit k_has_run, k_started;
	int k_isr;
	logic [15:0] k_sem[NSEM];
	logic [15:0] k_flags[NEV];

	kres_t pending_results[$];
	int errors = 0;
	int cycles = 0;

	function automatic int best_task(tstat_t st, logic [2:0] obj);
		int b;
		b = -1;
		for (int i = 0; i < NT; i++) begin
			if (k_stat[i] != st) continue;
			if (st != TS_READY && k_wobj[i] != obj) continue;
			if (b < 0 || k_prio[i] < k_prio[b]) b = i;
		end
		return b;
	endfunction

	function automatic bit flags_met(logic [15:0] f, logic [15:0] m, logic a);
		return a ? ((f & m) == m) : ((f & m) != 0);
	endfunction

	// advance the mirror by one op and return the result it should produce
	function automatic kres_t kernel_step(kop_t k);
		kres_t r;
		bit sched;
		int w;
		r = '0;
		sched = 0;
		case (k.op)
			OP_CREATE: begin
				if (k_created >= NT) r.status = ST_FULL;
				else begin
					r.newidx = k_created[3:0];
					k_stat[k_created] = TS_READY;
					k_prio[k_created] = k.prio;
					k_dly[k_created] = '0;
					k_wobj[k_created] = '0;
					k_wmask[k_created] = '0;
					k_wall[k_created] = 1'b0;
					k_created++;
					sched = k_started;
				end
			end
			OP_RUN: begin
				k_started = 1;
				sched = 1;
			end
			OP_DELAY: begin
				if (k.dly != 0) begin
					if (!k_has_run) r.status = ST_INVALID;
					else begin
						k_dly[k_run] = k.dly;
						k_stat[k_run] = TS_DELAYED;
						sched = 1;
					end
				end
			end
			OP_TICK: begin
				for (int i = 0; i < NT; i++)
					if (k_stat[i] == TS_DELAYED) begin
						k_dly[i]--;
						if (k_dly[i] == 0) k_stat[i] = TS_READY;
					end
			end
			OP_ISR_ENTER: if (k_isr < 255) k_isr++;
			OP_ISR_EXIT: begin
				if (k_isr == 0) r.status = ST_INVALID;
				else begin
					k_isr--;
					sched = (k_isr == 0) && k_started;
				end
			end
			OP_SEM_CREATE: k_sem[k.obj] = k.init;
			OP_SEM_PEND: begin
				if (k_sem[k.obj] > 0) k_sem[k.obj]--;
				else if (!k_has_run) r.status = ST_INVALID;
				else begin
					k_stat[k_run] = TS_SEM;
					k_wobj[k_run] = k.obj;
					r.status = ST_BLOCKED;
					sched = 1;
				end
			end
			OP_SEM_POST: begin
				w = best_task(TS_SEM, k.obj);
				if (w >= 0) k_stat[w] = TS_READY;
				else if (k_sem[k.obj] != 16'hffff) k_sem[k.obj]++;
				sched = (k_isr == 0) && k_started;
			end
			OP_EV_CREATE, OP_EV_PEND, OP_EV_SET, OP_EV_RESET: begin
				if (k.op == OP_EV_CREATE) k_flags[k.obj] = k.init;
				else if (k.op == OP_EV_PEND) begin
					if (!flags_met(k_flags[k.obj], k.mask, k.all)) begin
						if (!k_has_run) r.status = ST_INVALID;
						else begin
							k_stat[k_run] = TS_EVENT;
							k_wobj[k_run] = k.obj;
							k_wmask[k_run] = k.mask;
							k_wall[k_run] = k.all;
							r.status = ST_BLOCKED;
							sched = 1;
						end
					end
				end else if (k.op == OP_EV_SET) begin
					k_flags[k.obj] |= k.mask;
					for (int i = 0; i < NT; i++)
						if (k_stat[i] == TS_EVENT && k_wobj[i] == k.obj &&
								flags_met(k_flags[k.obj], k_wmask[i], k_wall[i]))
							k_stat[i] = TS_READY;
					sched = (k_isr == 0) && k_started;
				end else k_flags[k.obj] &= ~k.mask;
				r.flags = k_flags[k.obj];
			end
			default: r.status = ST_INVALID;
		endcase
		if (sched) begin
			w = best_task(TS_READY, 0);
			if (w < 0) begin
				k_has_run = 0;
				if (r.status == ST_DONE) r.status = ST_INVALID;
			end else begin
				if (!k_has_run || k_run != w[3:0]) begin
					k_run = w[3:0];
					r.sw = 1;
				end
				k_has_run = 1;
			end
		end
		r.cur = k_run;
		return r;
	endfunction

	function automatic void kernel_clear();
		for (int i = 0; i < NT; i++) k_stat[i] = TS_FREE;
		for (int i = 0; i < NSEM; i++) k_sem[i] = '0;
		for (int i = 0; i < NEV; i++) k_flags[i] = '0;
		k_created = 0;
		k_run = '0;
		k_has_run = 0;
		k_started = 0;
		k_isr = 0;
	endfunction

	// send one op: random gap, drive at falling edge, wait for acceptance;
	// valid stays high into the next call, which drops it when it idles
	task automatic send_op(kop_t k);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.op <= k.op;
		in_ch.priority_req <= k.prio;
		in_ch.delay_ticks <= k.dly;
		in_ch.obj_index <= k.obj;
		in_ch.init_value <= k.init;
		in_ch.mask <= k.mask;
		in_ch.wait_all <= k.all;
		in_ch.valid <= 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		pending_results.push_back(kernel_step(k));
		@(negedge clk);
	endtask

	function automatic kop_t mk(op_t op, logic [2:0] obj = 0, logic [15:0] v = 0,
			logic all = 0);
		kop_t k;
		k = '{op: op, prio: 8'($urandom), dly: 16'($urandom), obj: obj,
			init: 16'($urandom), mask: 16'($urandom), all: 1'($urandom)};
		if (op == OP_CREATE) k.prio = v[7:0];
		if (op == OP_DELAY) k.dly = v;
		if (op == OP_SEM_CREATE || op == OP_EV_CREATE) k.init = v;
		if (op == OP_EV_PEND || op == OP_EV_SET || op == OP_EV_RESET) begin
			k.mask = v;
			k.all = all;
		end
		return k;
	endfunction

	// pick a random op biased toward well-formed kernel traffic
	function automatic kop_t random_op();
		kop_t k;
		int sel;
		k = '{op: 4'($urandom), prio: 8'($urandom), dly: 16'($urandom),
			obj: 3'($urandom), init: 16'($urandom), mask: 16'($urandom),
			all: 1'($urandom)};
		sel = $urandom_range(0, 99);
		// mostly short delays so tasks come back within a few ticks
		if ($urandom_range(0, 9) != 0) k.dly = 16'($urandom_range(0, 4));
		if ($urandom_range(0, 3) != 0) k.mask = 16'(1) << $urandom_range(0, 15);
		if ($urandom_range(0, 9) != 0) k.init = 16'($urandom_range(0, 3));
		if (sel < 4) k.op = OP_CREATE;
		else if (sel < 16) k.op = OP_DELAY;
		else if (sel < 32) k.op = OP_TICK;
		else if (sel < 38) k.op = OP_ISR_ENTER;
		else if (sel < 44) k.op = OP_ISR_EXIT;
		else if (sel < 48) k.op = OP_SEM_CREATE;
		else if (sel < 58) k.op = OP_SEM_PEND;
		else if (sel < 68) k.op = OP_SEM_POST;
		else if (sel < 71) k.op = OP_EV_CREATE;
		else if (sel < 80) k.op = OP_EV_PEND;
		else if (sel < 89) k.op = OP_EV_SET;
		else if (sel < 94) k.op = OP_EV_RESET;
		else if (sel < 96) k.op = OP_RUN;
		else k.op = 4'($urandom_range(13, 15));
		return k;
	endfunction

	// result side: random wait per item, compare each accepted item with the oldest prediction
	initial begin
		kres_t got, want;
		int gap;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 13);
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			got = '{out_ch.current_task, out_ch.switched, out_ch.status,
				out_ch.flags_value, out_ch.new_task_index};
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.cur !== want.cur) begin
					$display("%0t: current_task exp %0d got %0d", $time, want.cur, got.cur);
					errors++;
				end
				if (got.sw !== want.sw) begin
					$display("%0t: switched exp %0d got %0d", $time, want.sw, got.sw);
					errors++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
					errors++;
				end
				if (got.flags !== want.flags) begin
					$display("%0t: flags_value exp %h got %h", $time, want.flags, got.flags);
					errors++;
				end
				if (got.newidx !== want.newidx) begin
					$display("%0t: new_task_index exp %0d got %0d", $time, want.newidx,
						got.newidx);
					errors++;
				end
			end
			@(negedge clk);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("rtos_task_scheduler verification failed");
			$finish;
		end
	end

	// errors before the kernel starts: nothing running, empty isr stack, unknown ops
	task automatic test_cold_start();
		send_op(mk(OP_DELAY, 0, 16'd5));
		send_op(mk(OP_DELAY, 0, 16'd0));
		send_op(mk(OP_ISR_EXIT));
		send_op(mk(OP_SEM_PEND, 3));
		send_op(mk(OP_EV_PEND, 7, 16'h0000, 1'b0));
		send_op(mk(OP_RUN));
		send_op('{op: 4'd15, prio: 8'hff, dly: 16'hffff, obj: 3'd7, init: 16'hffff,
			mask: 16'hffff, all: 1'b1});
		send_op('{op: 4'd13, default: '0});
	endtask

	// fill the table with extreme and tied priorities, then overflow it
	task automatic test_table_fill();
		send_op(mk(OP_CREATE, 0, 16'd255));
		send_op(mk(OP_CREATE, 0, 16'd0));
		send_op(mk(OP_CREATE, 0, 16'd0));
		for (int i = 3; i < NT; i++) send_op(mk(OP_CREATE, 0, 16'($urandom_range(0, 255))));
		send_op(mk(OP_CREATE, 0, 16'd1));
	endtask

	// semaphores, events and isr entry and exit on the full table
	task automatic test_objects();
		send_op(mk(OP_SEM_CREATE, 7, 16'hffff));
		send_op(mk(OP_SEM_POST, 7));
		send_op(mk(OP_SEM_PEND, 1));
		send_op(mk(OP_EV_CREATE, 0, 16'hffff));
		send_op(mk(OP_EV_PEND, 2, 16'h0000, 1'b1));
		send_op(mk(OP_EV_PEND, 2, 16'h0000, 1'b0));
		send_op(mk(OP_ISR_ENTER));
		send_op(mk(OP_SEM_POST, 1));
		send_op(mk(OP_EV_SET, 2, 16'h8001));
		send_op(mk(OP_ISR_EXIT));
		send_op(mk(OP_EV_RESET, 0, 16'hffff));
		send_op(mk(OP_DELAY, 0, 16'hffff));
		send_op(mk(OP_TICK));
	endtask

	task automatic test_isr_saturation();
		for (int i = 0; i < 260; i++) send_op(mk(OP_ISR_ENTER));
		for (int i = 0; i < 256; i++) send_op(mk(OP_ISR_EXIT));
	endtask

	task automatic test_random_traffic();
		for (int i = 0; i < 1000; i++) begin
			send_op(random_op());
			// let the whole pipeline drain once mid-run
			if (i == 500) begin
				in_ch.valid <= 1'b0;
				wait (pending_results.size() == 0);
				@(negedge clk);
			end
		end
	endtask

	initial begin
		kernel_clear();
		in_ch.valid = 1'b0;
		in_ch.op = '0;
		in_ch.priority_req = '0;
		in_ch.delay_ticks = '0;
		in_ch.obj_index = '0;
		in_ch.init_value = '0;
		in_ch.mask = '0;
		in_ch.wait_all = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_cold_start();
		test_table_fill();
		test_objects();
		test_isr_saturation();
		test_random_traffic();
		in_ch.valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("rtos_task_scheduler verification clean");
		end else begin
			$display("rtos_task_scheduler verification failed");
		end
		$finish;
	end
endmodule

FILE: files.f
rtl/core/rts_pkg.sv
rtl/core/rts_if.sv
rtl/core/rtos_task_scheduler.sv
bench/rtos_task_scheduler_tb.sv
